// ----- sv/ctbs_pkg.sv -----
`default_nettype none
package ctbs_pkg;

  // Stream and configuration port widths
  localparam int unsigned KindW    = 2;
  localparam int unsigned InDataW  = 88;
  localparam int unsigned OutDataW = 80;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Divider widths: 32-bit elapsed time over a 16-bit interval
  localparam int unsigned DivNumW = 32;
  localparam int unsigned DivDenW = 16;
  localparam int unsigned DivCntW = $clog2(DivNumW);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE        = 3'd0,
    CFG_INTERVAL    = 3'd1,
    CFG_BURST       = 3'd2,
    CFG_FAIL_LIMIT  = 3'd3,
    CFG_COOLDOWN    = 3'd4,
    CFG_STATS_IV    = 3'd5,
    CFG_HV_EN       = 3'd6
  } cfg_idx_e;

  typedef enum logic [KindW-1:0] {
    KIND_CLICK = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_SEND  = 2'd2
  } kind_e;

  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_CLICKS = 2'd2;

  localparam logic [1:0] PHASE_STATS = 2'd0;
  localparam logic [1:0] PHASE_HV    = 2'd1;
  localparam logic [1:0] PHASE_SYS   = 2'd2;

  localparam logic [7:0] FAIL_MAX = 8'd255;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] interval;
    logic [7:0]  burst;
    logic [7:0]  fail_limit;
    logic [15:0] cooldown;
    logic [15:0] stats_iv;
    logic        hv_en;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    mode:       2'd0,
    interval:   16'd100,
    burst:      8'd4,
    fail_limit: 8'd3,
    cooldown:   16'd60,
    stats_iv:   16'd60,
    hv_en:      1'b0
  };

endpackage
`default_nettype wire

// ----- sv/ctbs_cfg_regs.sv -----
`default_nettype none
module ctbs_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ctbs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ctbs_pkg::CfgDataW-1:0]  cfg_data_i,
  output ctbs_pkg::cfg_t                 cfg_o
);
  import ctbs_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MODE:       cfg_d.mode       = cfg_data_i[1:0];
        CFG_INTERVAL:   cfg_d.interval   = cfg_data_i[15:0];
        CFG_BURST:      cfg_d.burst      = cfg_data_i[7:0];
        CFG_FAIL_LIMIT: cfg_d.fail_limit = cfg_data_i[7:0];
        CFG_COOLDOWN:   cfg_d.cooldown   = cfg_data_i[15:0];
        CFG_STATS_IV:   cfg_d.stats_iv   = cfg_data_i[15:0];
        CFG_HV_EN:      cfg_d.hv_en      = cfg_data_i[0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ----- sv/ctbs_div.sv -----
`default_nettype none
module ctbs_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ctbs_pkg::DivNumW-1:0]  dividend_i,
  input  logic [ctbs_pkg::DivDenW-1:0]  divisor_i,
  output logic                          done_o,
  output logic [ctbs_pkg::DivNumW-1:0]  quot_o,
  output logic [ctbs_pkg::DivDenW-1:0]  rem_o
);
  import ctbs_pkg::*;

  logic               run_q, run_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DivNumW-1:0] dvd_q, dvd_d;
  logic [DivDenW-1:0] rem_q, rem_d;
  logic [DivDenW-1:0] den_q, den_d;
  logic [DivDenW:0]   trial;
  logic [DivDenW:0]   diff;
  logic               qbit;

  // One restoring step per cycle; quotient bits shift in behind the dividend
  always_comb begin
    trial = {rem_q, dvd_q[DivNumW-1]};
    diff  = trial - {1'b0, den_q};
    qbit  = (trial >= {1'b0, den_q});

    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    den_d  = den_q;

    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      dvd_d = dividend_i;
      rem_d = '0;
      den_d = divisor_i;
    end else if (run_q) begin
      dvd_d = {dvd_q[DivNumW-2:0], qbit};
      rem_d = qbit ? diff[DivDenW-1:0] : trial[DivDenW-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == '1) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

// ----- sv/click_token_bucket_scheduler_top.sv -----
`default_nettype none
// Click token bucket scheduler. Each request on the slave stream (kind in
// tuser: click/poll, one-second tick, send outcome) yields exactly one result
// on the master stream. A click request that needs a bucket refill divides
// the elapsed time by the click interval in a restoring divider, one quotient
// bit per cycle, through the evaluate, divide, spend and put states. A click
// that spends without a refill skips the divide; every other request goes
// from evaluate to put. The block takes one request at a time and drops tready
// while it works; a finished result waits in the output register, so the next
// request can be accepted on the edge at which the result is taken, or before.
// A result stalled by m_axis_tready holds the next request in its last step
// until the output register frees. The user writes configuration through
// cfg_we_i/cfg_idx_i/cfg_data_i while idle; the block does not enforce it.
module click_token_bucket_scheduler_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [ctbs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ctbs_pkg::CfgDataW-1:0]  cfg_data_i,
  // request stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: now_ms[31:0], counted_clicks[63:32], pending_clicks[79:64],
  //        wifi_up[80], link_ready[81], ota_busy[82], send_ok[83], zero[87:84]
  input  logic [ctbs_pkg::InDataW-1:0]   s_axis_tdata,
  // tuser: kind[1:0]
  input  logic [ctbs_pkg::KindW-1:0]     s_axis_tuser,
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: click_emit[0], click_count[32:1], click_time[64:33], send_rad[65],
  //        send_hv[66], send_sys[67], send_env[68], failures[76:69],
  //        backing_off[77], zero[79:78]
  output logic [ctbs_pkg::OutDataW-1:0]  m_axis_tdata
);
  import ctbs_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EVAL  = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_SPEND = 5'b01000,
    ST_PUT   = 5'b10000
  } state_e;

  cfg_t cfg;

  state_e state_q, state_d;

  // latched request
  kind_e       kind_q;
  logic [31:0] now_q;
  logic [31:0] total_q;
  logic        wifi_q, link_q, ota_q, ok_q;

  // scheduler state
  logic [7:0]  tokens_q, tokens_d;
  logic [31:0] token_time_q, token_time_d;
  logic [31:0] reported_q, reported_d;
  logic [7:0]  fail_q, fail_d;
  logic [15:0] backoff_q, backoff_d;
  logic [15:0] stats_q, stats_d;
  logic [1:0]  phase_q, phase_d;
  logic        toggle_q, toggle_d;

  // result under construction
  logic        emit_q, emit_d;
  logic [31:0] cnt_q, cnt_d;
  logic [31:0] ts_q, ts_d;
  logic        rad_q, rad_d, hv_q, hv_d, sys_q, sys_d, env_q, env_d;

  logic                m_valid_q, m_valid_d;
  logic [OutDataW-1:0] m_data_q, m_data_d;

  logic               s_accept;
  logic               link_ok;
  logic [15:0]        iv;
  logic [31:0]        elapsed;
  logic               click_ok;
  logic               refill;
  logic               div_start;
  logic               div_done;
  logic [DivNumW-1:0] div_quot;
  logic [DivDenW-1:0] div_rem;
  logic [31:0]        filled;
  logic [15:0]        backoff_inc;
  logic [15:0]        stats_inc;
  logic               backing;

  ctbs_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ctbs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (elapsed),
    .divisor_i  (iv),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign link_ok   = wifi_q && link_q;
  assign iv        = (cfg.interval == '0) ? 16'd1 : cfg.interval;
  assign elapsed   = now_q - token_time_q;
  assign refill    = (elapsed >= {16'd0, iv});
  assign click_ok  = (cfg.mode == MODE_CLICKS) && (fail_q < cfg.fail_limit) && link_ok &&
                     !ota_q && (total_q != reported_q);
  assign div_start = (state_q == ST_EVAL) && (kind_q == KIND_CLICK) && click_ok && refill;

  // refill sum wraps at 32 bits before the burst cap
  assign filled      = {24'd0, tokens_q} + div_quot;
  assign backoff_inc = backoff_q + 16'd1;
  assign stats_inc   = stats_q + 16'd1;
  assign backing     = (fail_q >= cfg.fail_limit);

  always_comb begin
    state_d      = state_q;
    tokens_d     = tokens_q;
    token_time_d = token_time_q;
    reported_d   = reported_q;
    fail_d       = fail_q;
    backoff_d    = backoff_q;
    stats_d      = stats_q;
    phase_d      = phase_q;
    toggle_d     = toggle_q;
    emit_d       = emit_q;
    cnt_d        = cnt_q;
    ts_d         = ts_q;
    rad_d        = rad_q;
    hv_d         = hv_q;
    sys_d        = sys_q;
    env_d        = env_q;
    m_valid_d    = m_valid_q;
    m_data_d     = m_data_q;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        emit_d  = 1'b0;
        cnt_d   = '0;
        ts_d    = '0;
        rad_d   = 1'b0;
        hv_d    = 1'b0;
        sys_d   = 1'b0;
        env_d   = 1'b0;
        state_d = ST_PUT;
        unique case (kind_q)
          KIND_CLICK: begin
            if (click_ok) begin
              state_d = refill ? ST_DIV : ST_SPEND;
            end
          end
          KIND_TICK: begin
            if ((cfg.mode != MODE_OFF) && !ota_q && link_ok) begin
              if (backing) begin
                // cooldown: clear failures once enough ticks have passed
                if (backoff_inc >= cfg.cooldown) begin
                  fail_d    = '0;
                  backoff_d = '0;
                end else begin
                  backoff_d = backoff_inc;
                end
              end else begin
                unique case (phase_q)
                  PHASE_STATS: begin
                    if (stats_inc >= cfg.stats_iv) begin
                      stats_d = '0;
                      rad_d   = 1'b1;
                      phase_d = PHASE_HV;
                    end else begin
                      stats_d = stats_inc;
                    end
                  end
                  PHASE_HV: begin
                    hv_d    = cfg.hv_en;
                    phase_d = PHASE_SYS;
                  end
                  default: begin
                    // sys and env go out on every second pass
                    toggle_d = !toggle_q;
                    sys_d    = !toggle_q;
                    env_d    = !toggle_q;
                    phase_d  = PHASE_STATS;
                  end
                endcase
              end
            end
          end
          KIND_SEND: begin
            if (link_ok) begin
              if (ok_q) begin
                fail_d = '0;
              end else if (fail_q != FAIL_MAX) begin
                fail_d = fail_q + 8'd1;
              end
            end
          end
          default: begin
            state_d = ST_PUT;
          end
        endcase
      end
      ST_DIV: begin
        if (div_done) begin
          tokens_d     = (filled > {24'd0, cfg.burst}) ? cfg.burst : filled[7:0];
          // leftover time carries forward
          token_time_d = now_q - {16'd0, div_rem};
          state_d      = ST_SPEND;
        end
      end
      ST_SPEND: begin
        if (tokens_q != '0) begin
          tokens_d   = tokens_q - 8'd1;
          reported_d = total_q;
          emit_d     = 1'b1;
          cnt_d      = total_q;
          ts_d       = now_q;
        end
        state_d = ST_PUT;
      end
      ST_PUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {2'b00, backing, fail_q, env_q, sys_q, hv_q, rad_q, ts_q, cnt_q,
                       emit_q};
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      tokens_q     <= '0;
      token_time_q <= '0;
      reported_q   <= '0;
      fail_q       <= '0;
      backoff_q    <= '0;
      stats_q      <= '0;
      phase_q      <= PHASE_STATS;
      toggle_q     <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      tokens_q     <= tokens_d;
      token_time_q <= token_time_d;
      reported_q   <= reported_d;
      fail_q       <= fail_d;
      backoff_q    <= backoff_d;
      stats_q      <= stats_d;
      phase_q      <= phase_d;
      toggle_q     <= toggle_d;
      m_valid_q    <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      kind_q  <= kind_e'(s_axis_tuser);
      now_q   <= s_axis_tdata[31:0];
      total_q <= s_axis_tdata[63:32] + {16'd0, s_axis_tdata[79:64]};
      wifi_q  <= s_axis_tdata[80];
      link_q  <= s_axis_tdata[81];
      ota_q   <= s_axis_tdata[82];
      ok_q    <= s_axis_tdata[83];
    end
    emit_q   <= emit_d;
    cnt_q    <= cnt_d;
    ts_q     <= ts_d;
    rad_q    <= rad_d;
    hv_q     <= hv_d;
    sys_q    <= sys_d;
    env_q    <= env_d;
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside the refill state");

  a_spend_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SPEND) && (tokens_q != '0)) |=> (tokens_q == $past(tokens_q) - 8'd1))
    else $error("report did not spend exactly one token");

  a_fail_only_in_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_EVAL) |=> $stable(fail_q))
    else $error("failure count changed outside evaluation");

  a_phase_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PHASE_STATS) || (phase_q == PHASE_HV) || (phase_q == PHASE_SYS))
    else $error("telemetry sequencer left its three phases");

  a_no_accept_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_start || (state_q == ST_DIV)) |-> !s_axis_tready)
    else $error("request taken while a refill divide runs");

endmodule
`default_nettype wire
